### hdl/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg: motor command sequencer shared definitions
// Codes, payload and state types, frame constants and the command packer.
// ----------------------------------------------------------------------------
package mcs_pkg;

  localparam int TICK_W     = 10;
  localparam int POS_W      = 16;
  localparam int CODE12_W   = 12;
  localparam int KEY_W      = 32;
  localparam int FRAME_W    = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [FRAME_W-1:0]  FRAME_ENTER  = 64'hFFFF_FFFF_FFFF_FFFC;
  localparam logic [FRAME_W-1:0]  FRAME_EXIT   = 64'hFFFF_FFFF_FFFF_FFFD;
  // zero velocity / torque code for a symmetric range
  localparam logic [CODE12_W-1:0] ZERO_CODE_12 = 12'd2047;

  localparam logic [TICK_W-1:0]   RST_ENTER_DELAY   = 10'd20;
  localparam logic [TICK_W-1:0]   RST_FEEDBACK_HOLD = 10'd200;
  localparam logic [TICK_W-1:0]   RST_MOTION_HOLD   = 10'd800;
  localparam logic [POS_W-1:0]    RST_MOVE_POS      = 16'd33029;
  localparam logic [POS_W-1:0]    RST_HOME_POS      = 16'd32767;
  localparam logic [CODE12_W-1:0] RST_MOTION_KP     = 12'd81;
  localparam logic [CODE12_W-1:0] RST_MOTION_KD     = 12'd81;
  localparam logic [KEY_W-1:0]    RST_UNLOCK_KEY    = 32'hA453_6001;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_USER   = 2'd1,
    REQ_UNLOCK = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    RQ_NONE      = 3'd0,
    RQ_DISABLE   = 3'd1,
    RQ_HANDSHAKE = 3'd2,
    RQ_MOVE_PLUS = 3'd3,
    RQ_MOVE_HOME = 3'd4
  } request_t;

  typedef enum logic [2:0] {
    RES_READY   = 3'd0,
    RES_RUNNING = 3'd1,
    RES_OK      = 3'd2,
    RES_LOCKED  = 3'd3,
    RES_BUSY    = 3'd4,
    RES_BAD     = 3'd5,
    RES_TXERR   = 3'd6
  } result_t;

  typedef enum logic [1:0] {
    SEQ_IDLE        = 2'd0,
    SEQ_WAIT_ZERO   = 2'd1,
    SEQ_WAIT_MOTION = 2'd2,
    SEQ_WAIT_EXIT   = 2'd3
  } seq_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTER_DELAY   = 3'd0,
    CFG_FEEDBACK_HOLD = 3'd1,
    CFG_MOTION_HOLD   = 3'd2,
    CFG_MOVE_POS      = 3'd3,
    CFG_HOME_POS      = 3'd4,
    CFG_MOTION_KP     = 3'd5,
    CFG_MOTION_KD     = 3'd6,
    CFG_UNLOCK_KEY    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  request_code;
    logic [31:0] unlock_value;
    logic        tx_ready;
  } mcs_in_t;

  typedef struct packed {
    logic               frame_valid;
    logic [FRAME_W-1:0] frame_data;
    logic [2:0]         result_code;
    logic [1:0]         seq_state;
    logic               motor_enabled;
    logic [2:0]         last_request;
  } mcs_out_t;

  typedef struct packed {
    logic [TICK_W-1:0]   enter_delay;
    logic [TICK_W-1:0]   feedback_hold;
    logic [TICK_W-1:0]   motion_hold;
    logic [POS_W-1:0]    move_pos;
    logic [POS_W-1:0]    home_pos;
    logic [CODE12_W-1:0] motion_kp;
    logic [CODE12_W-1:0] motion_kd;
    logic [KEY_W-1:0]    unlock_key;
  } mcs_cfg_t;

  typedef struct packed {
    seq_t              seq;
    logic [TICK_W-1:0] ticks;
    logic [KEY_W-1:0]  unlock;
    logic              target_move;
    logic              enabled;
    result_t           result;
    logic [2:0]        last_req;
  } mcs_state_t;

  // position(16) | velocity(12) | kp(12) | kd(12) | torque(12)
  function automatic logic [FRAME_W-1:0] pack_cmd(
    input logic [POS_W-1:0]    pos,
    input logic [CODE12_W-1:0] vel,
    input logic [CODE12_W-1:0] kp,
    input logic [CODE12_W-1:0] kd,
    input logic [CODE12_W-1:0] trq
  );
    return {pos, vel, kp, kd, trq};
  endfunction

endpackage

### hdl/mcs_stream_if.sv
// ----------------------------------------------------------------------------
// mcs_stream_if: valid/ready channel
// Carries one payload item per handshake; source drives valid and data.
// ----------------------------------------------------------------------------
interface mcs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/mcs_step.sv
// ----------------------------------------------------------------------------
// mcs_step: sequencer next-state logic
// Works out the next sequence state and the result item for one input item.
// ----------------------------------------------------------------------------
module mcs_step (
  input  mcs_pkg::mcs_in_t    item,
  input  mcs_pkg::mcs_cfg_t   cfg,
  input  mcs_pkg::mcs_state_t st,
  output mcs_pkg::mcs_state_t st_next,
  output mcs_pkg::mcs_out_t   result
);
  import mcs_pkg::*;

  logic [TICK_W-1:0]  ticks_dec;
  logic [FRAME_W-1:0] tick_frame;
  logic [TICK_W-1:0]  tick_hold;
  logic               key_ok;
  logic               fv;
  logic [FRAME_W-1:0] fd;

  assign ticks_dec = (st.ticks != '0) ? st.ticks - 1'b1 : st.ticks;
  assign key_ok    = (st.unlock == cfg.unlock_key);

  // frame sent when the countdown expires, and the hold that follows it
  always_comb begin
    tick_frame = FRAME_EXIT;
    tick_hold  = '0;
    unique case (st.seq)
      SEQ_WAIT_ZERO: begin
        tick_frame = pack_cmd(cfg.home_pos, ZERO_CODE_12, '0, '0, ZERO_CODE_12);
        tick_hold  = cfg.feedback_hold;
      end
      SEQ_WAIT_MOTION: begin
        tick_frame = pack_cmd(st.target_move ? cfg.move_pos : cfg.home_pos, ZERO_CODE_12,
                              cfg.motion_kp, cfg.motion_kd, ZERO_CODE_12);
        tick_hold  = cfg.motion_hold;
      end
      SEQ_WAIT_EXIT, SEQ_IDLE: begin
        tick_frame = FRAME_EXIT;
        tick_hold  = '0;
      end
    endcase
  end

  always_comb begin
    st_next = st;
    fv      = 1'b0;
    fd      = '0;
    unique case (item.req_type)
      REQ_TICK: begin
        if (st.seq != SEQ_IDLE) begin
          st_next.ticks = ticks_dec;
          if (ticks_dec == '0) begin
            if (!item.tx_ready) begin
              // refused send: best-effort exit is refused too
              st_next.enabled = 1'b0;
              st_next.seq     = SEQ_IDLE;
              st_next.unlock  = '0;
              st_next.result  = RES_TXERR;
            end else begin
              fv = 1'b1;
              fd = tick_frame;
              if (st.seq == SEQ_WAIT_EXIT) begin
                st_next.enabled = 1'b0;
                st_next.seq     = SEQ_IDLE;
                st_next.unlock  = '0;
                st_next.result  = RES_OK;
              end else begin
                st_next.ticks = tick_hold;
                st_next.seq   = SEQ_WAIT_EXIT;
              end
            end
          end
        end
      end
      REQ_USER: begin
        priority if (item.request_code == RQ_DISABLE) begin
          st_next.last_req = item.request_code;
          st_next.seq      = SEQ_IDLE;
          st_next.unlock   = '0;
          st_next.enabled  = 1'b0;
          if (item.tx_ready) begin
            fv             = 1'b1;
            fd             = FRAME_EXIT;
            st_next.result = RES_OK;
          end else begin
            st_next.result = RES_TXERR;
          end
        end else if (item.request_code == RQ_NONE) begin
          st_next = st;
        end else if (st.seq != SEQ_IDLE) begin
          st_next.result = RES_BUSY;
        end else begin
          st_next.last_req = item.request_code;
          st_next.result   = RES_RUNNING;
          priority if (item.request_code == RQ_HANDSHAKE) begin
            if (item.tx_ready) begin
              fv              = 1'b1;
              fd              = FRAME_ENTER;
              st_next.enabled = 1'b1;
              st_next.ticks   = cfg.enter_delay;
              st_next.seq     = SEQ_WAIT_ZERO;
            end else begin
              st_next.unlock = '0;
              st_next.result = RES_TXERR;
            end
          end else if (item.request_code == RQ_MOVE_PLUS ||
                       item.request_code == RQ_MOVE_HOME) begin
            if (!key_ok) begin
              st_next.unlock = '0;
              st_next.result = RES_LOCKED;
            end else begin
              st_next.target_move = (item.request_code == RQ_MOVE_PLUS);
              if (item.tx_ready) begin
                fv              = 1'b1;
                fd              = FRAME_ENTER;
                st_next.enabled = 1'b1;
                st_next.ticks   = cfg.enter_delay;
                st_next.seq     = SEQ_WAIT_MOTION;
              end else begin
                st_next.unlock = '0;
                st_next.result = RES_TXERR;
              end
            end
          end else begin
            st_next.result = RES_BAD;
          end
        end
      end
      REQ_UNLOCK: begin
        st_next.unlock = item.unlock_value;
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  always_comb begin
    result.frame_valid   = fv;
    result.frame_data    = fd;
    result.result_code   = st_next.result;
    result.seq_state     = st_next.seq;
    result.motor_enabled = st_next.enabled;
    result.last_request  = st_next.last_req;
  end

endmodule

### hdl/motor_command_sequencer.sv
// ----------------------------------------------------------------------------
// motor_command_sequencer: motor enter / command / exit frame sequencer
// Runs handshake and move test sequences and reports status per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one item per handshake - a millisecond tick, a user request or
//            an unlock key write, plus the transmit queue's tx_ready flag.
//   out_ch : exactly one result item per input item - the frame sent (if
//            any) and the result, sequence state, enable and last request.
//   cfg_*  : register write port, index 0..7; user writes only while idle (unchecked).
// The item is decoded against the sequence state in the accept cycle and its
// result is captured in the output register at the edge that accepts it.
// Throughput is one item per cycle; a new item is accepted whenever
// the output register is empty or is being taken in the same cycle.
// If the receiver stalls, the result holds and in_ch.ready drops until the
// result is taken.
// Reset loads the register defaults, returns the sequencer to idle with the
// motor disabled, clears the unlock store and empties the output register.
// ----------------------------------------------------------------------------
module motor_command_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  mcs_stream_if.sink                         in_ch,
  mcs_stream_if.source                       out_ch,
  input  logic                               cfg_we,
  input  logic [mcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mcs_pkg::*;

  mcs_cfg_t   cfg;
  mcs_state_t st;
  mcs_state_t st_next;
  mcs_out_t   step_result;
  mcs_out_t   out_data;
  logic       out_valid;
  logic       in_fire;

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  mcs_step u_step (
    .item    (in_ch.data),
    .cfg     (cfg),
    .st      (st),
    .st_next (st_next),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enter_delay   <= RST_ENTER_DELAY;
      cfg.feedback_hold <= RST_FEEDBACK_HOLD;
      cfg.motion_hold   <= RST_MOTION_HOLD;
      cfg.move_pos      <= RST_MOVE_POS;
      cfg.home_pos      <= RST_HOME_POS;
      cfg.motion_kp     <= RST_MOTION_KP;
      cfg.motion_kd     <= RST_MOTION_KD;
      cfg.unlock_key    <= RST_UNLOCK_KEY;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENTER_DELAY:   cfg.enter_delay   <= cfg_data[TICK_W-1:0];
        CFG_FEEDBACK_HOLD: cfg.feedback_hold <= cfg_data[TICK_W-1:0];
        CFG_MOTION_HOLD:   cfg.motion_hold   <= cfg_data[TICK_W-1:0];
        CFG_MOVE_POS:      cfg.move_pos      <= cfg_data[POS_W-1:0];
        CFG_HOME_POS:      cfg.home_pos      <= cfg_data[POS_W-1:0];
        CFG_MOTION_KP:     cfg.motion_kp     <= cfg_data[CODE12_W-1:0];
        CFG_MOTION_KD:     cfg.motion_kd     <= cfg_data[CODE12_W-1:0];
        CFG_UNLOCK_KEY:    cfg.unlock_key    <= cfg_data[KEY_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.seq         <= SEQ_IDLE;
      st.ticks       <= '0;
      st.unlock      <= '0;
      st.target_move <= 1'b0;
      st.enabled     <= 1'b0;
      st.result      <= RES_READY;
      st.last_req    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (in_fire) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= step_result;
    end
  end

`ifndef ASSERT_OFF
  a_fire_fills_output: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted item produced no result");

  a_enabled_iff_running: assert property (@(posedge clk) disable iff (rst)
    (st.seq != SEQ_IDLE) == st.enabled)
    else $error("motor enable disagrees with sequence state");

  a_no_frame_zero_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.frame_valid) |-> (out_data.frame_data == '0))
    else $error("frame data set without a sent frame");

  a_cfg_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && !in_fire) |=> $stable(st))
    else $error("register write disturbed sequence state");
`endif

endmodule

### tb/mcs_frame_checker.sv
// ----------------------------------------------------------------------------
// mcs_frame_checker: result checker for the motor command sequencer
// Watches the item, result and register write ports, predicts the frame and
// status of every accepted item and compares each result item with the
// oldest prediction. Hands the mismatch count and the number of results
// still awaited to the testbench top.
// ----------------------------------------------------------------------------
module mcs_frame_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  mcs_pkg::mcs_in_t               in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  mcs_pkg::mcs_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [mcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             waiting
);
  import mcs_pkg::*;

  mcs_cfg_t   regs;
  mcs_state_t st;
  mcs_out_t   frame_status_q[$];

  initial begin
    errors  = 0;
    waiting = 0;
  end

  // refused send: best-effort exit is refused as well, sequencer drops out
  function automatic void drop_sequence();
    st.enabled = 1'b0;
    st.seq     = SEQ_IDLE;
    st.unlock  = '0;
    st.result  = RES_TXERR;
  endfunction

  function automatic mcs_out_t predict_frame_status(input mcs_in_t it);
    mcs_out_t           r;
    logic [FRAME_W-1:0] frm;
    logic               sent;
    logic               start;
    seq_t               next_seq;
    r        = '0;
    frm      = '0;
    sent     = 1'b0;
    start    = 1'b0;
    next_seq = SEQ_IDLE;
    case (it.req_type)
      REQ_TICK: begin
        if (st.seq != SEQ_IDLE) begin
          if (st.ticks != '0) st.ticks = st.ticks - 1'b1;
          if (st.ticks == '0) begin
            case (st.seq)
              SEQ_WAIT_ZERO:
                frm = {regs.home_pos, ZERO_CODE_12, 12'd0, 12'd0, ZERO_CODE_12};
              SEQ_WAIT_MOTION:
                frm = {(st.target_move ? regs.move_pos : regs.home_pos), ZERO_CODE_12,
                       regs.motion_kp, regs.motion_kd, ZERO_CODE_12};
              default:
                frm = FRAME_EXIT;
            endcase
            if (!it.tx_ready) begin
              drop_sequence();
            end else begin
              sent = 1'b1;
              case (st.seq)
                SEQ_WAIT_ZERO: begin
                  st.ticks = regs.feedback_hold;
                  st.seq   = SEQ_WAIT_EXIT;
                end
                SEQ_WAIT_MOTION: begin
                  st.ticks = regs.motion_hold;
                  st.seq   = SEQ_WAIT_EXIT;
                end
                default: begin
                  st.enabled = 1'b0;
                  st.seq     = SEQ_IDLE;
                  st.unlock  = '0;
                  st.result  = RES_OK;
                end
              endcase
            end
          end
        end
      end
      REQ_USER: begin
        if (it.request_code == RQ_DISABLE) begin
          // disable aborts from any state
          st.last_req = RQ_DISABLE;
          st.seq      = SEQ_IDLE;
          st.unlock   = '0;
          if (it.tx_ready) begin
            sent       = 1'b1;
            frm        = FRAME_EXIT;
            st.enabled = 1'b0;
            st.result  = RES_OK;
          end else begin
            drop_sequence();
          end
        end else if (it.request_code != RQ_NONE) begin
          if (st.seq != SEQ_IDLE) begin
            st.result = RES_BUSY;
          end else begin
            st.last_req = it.request_code;
            st.result   = RES_RUNNING;
            if (it.request_code == RQ_HANDSHAKE) begin
              start    = 1'b1;
              next_seq = SEQ_WAIT_ZERO;
            end else if (it.request_code == RQ_MOVE_PLUS ||
                         it.request_code == RQ_MOVE_HOME) begin
              if (st.unlock != regs.unlock_key) begin
                st.unlock = '0;
                st.result = RES_LOCKED;
              end else begin
                st.target_move = (it.request_code == RQ_MOVE_PLUS);
                start          = 1'b1;
                next_seq       = SEQ_WAIT_MOTION;
              end
            end else begin
              st.result = RES_BAD;
            end
            if (start) begin
              if (!it.tx_ready) begin
                drop_sequence();
              end else begin
                sent       = 1'b1;
                frm        = FRAME_ENTER;
                st.enabled = 1'b1;
                st.ticks   = regs.enter_delay;
                st.seq     = next_seq;
              end
            end
          end
        end
      end
      REQ_UNLOCK: st.unlock = it.unlock_value;
      default: ;
    endcase
    r.frame_valid   = sent;
    r.frame_data    = sent ? frm : '0;
    r.result_code   = st.result;
    r.seq_state     = st.seq;
    r.motor_enabled = st.enabled;
    r.last_request  = st.last_req;
    return r;
  endfunction

  always @(posedge clk) begin
    mcs_out_t want;
    if (rst) begin
      regs = '{enter_delay: RST_ENTER_DELAY, feedback_hold: RST_FEEDBACK_HOLD,
               motion_hold: RST_MOTION_HOLD, move_pos: RST_MOVE_POS,
               home_pos: RST_HOME_POS, motion_kp: RST_MOTION_KP,
               motion_kd: RST_MOTION_KD, unlock_key: RST_UNLOCK_KEY};
      st   = '{seq: SEQ_IDLE, ticks: '0, unlock: '0, target_move: 1'b0,
               enabled: 1'b0, result: RES_READY, last_req: '0};
      frame_status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENTER_DELAY:   regs.enter_delay   = cfg_data[TICK_W-1:0];
          CFG_FEEDBACK_HOLD: regs.feedback_hold = cfg_data[TICK_W-1:0];
          CFG_MOTION_HOLD:   regs.motion_hold   = cfg_data[TICK_W-1:0];
          CFG_MOVE_POS:      regs.move_pos      = cfg_data[POS_W-1:0];
          CFG_HOME_POS:      regs.home_pos      = cfg_data[POS_W-1:0];
          CFG_MOTION_KP:     regs.motion_kp     = cfg_data[CODE12_W-1:0];
          CFG_MOTION_KD:     regs.motion_kd     = cfg_data[CODE12_W-1:0];
          CFG_UNLOCK_KEY:    regs.unlock_key    = cfg_data[KEY_W-1:0];
          default: ;
        endcase
      end
      // the result taken at this edge belongs to an earlier item: pop first
      if (out_valid && out_ready) begin
        if (frame_status_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result item: data %h result %0d state %0d",
                     out_data.frame_data, out_data.result_code, out_data.seq_state);
        end else begin
          want = frame_status_q.pop_front();
          if (out_data.frame_valid   !== want.frame_valid   ||
              out_data.frame_data    !== want.frame_data    ||
              out_data.result_code   !== want.result_code   ||
              out_data.seq_state     !== want.seq_state     ||
              out_data.motor_enabled !== want.motor_enabled ||
              out_data.last_request  !== want.last_request) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch (expected/actual): valid %0b/%0b data %h/%h",
                        " result %0d/%0d state %0d/%0d enabled %0b/%0b last %0d/%0d"},
                       want.frame_valid, out_data.frame_valid,
                       want.frame_data, out_data.frame_data,
                       want.result_code, out_data.result_code,
                       want.seq_state, out_data.seq_state,
                       want.motor_enabled, out_data.motor_enabled,
                       want.last_request, out_data.last_request);
          end
        end
      end
      if (in_valid && in_ready)
        frame_status_q.push_back(predict_frame_status(in_data));
    end
    waiting = frame_status_q.size();
  end

endmodule

### tb/motor_command_sequencer_test.sv
// ----------------------------------------------------------------------------
// motor_command_sequencer_test: testbench top for the motor command sequencer
// Drives directed items, then well-formed handshake and move sequences mixed
// with noise under several register settings and idling mixes, including a
// long receiver hold-off. Checking is done by mcs_frame_checker.
// ----------------------------------------------------------------------------
module motor_command_sequencer_test;
  import mcs_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;
  // long register settings would need thousands of ticks per run
  localparam int SPAN_CAP    = 48;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mcs_stream_if #(.payload_t(mcs_in_t))  in_ch ();
  mcs_stream_if #(.payload_t(mcs_out_t)) out_ch ();

  int       mismatch_count;
  int       pending_count;
  int       n_in;
  int       n_out;
  int       quiet;
  int       send_idle;
  int       recv_stall;
  int       hold_req_cnt;
  int       stim_count;
  mcs_cfg_t cur;

  motor_command_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mcs_frame_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (mismatch_count),
    .waiting   (pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // handshake counters and watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst) begin
      n_in  <= 0;
      n_out <= 0;
      quiet <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) n_in <= n_in + 1;
      if (out_ch.valid && out_ch.ready) n_out <= n_out + 1;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // result side: random stalls, plus a long hold-off whenever one is requested
  initial begin : result_sink
    int held_left;
    int hold_done;
    held_left = 0;
    hold_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (held_left > 0) begin
        out_ch.ready <= 1'b0;
        held_left--;
      end else if (hold_req_cnt != hold_done) begin
        hold_done++;
        held_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  function automatic mcs_in_t mk(input logic [1:0] kind, input logic [2:0] code,
                                 input logic [31:0] val, input logic rdy);
    mcs_in_t it;
    it.req_type     = kind;
    it.request_code = code;
    it.unlock_value = val;
    it.tx_ready     = rdy;
    return it;
  endfunction

  function automatic mcs_in_t rand_item();
    return mk(2'($urandom_range(3)), 3'($urandom_range(7)), $urandom,
              1'($urandom_range(1)));
  endfunction

  // returns at the edge where the item is accepted; valid stays high
  task automatic push_item(input mcs_in_t it);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (it.req_type != 2'd3) stim_count++;
  endtask

  // stop the sequencer, then wait until every result item has come back
  task automatic drain();
    push_item(mk(REQ_USER, RQ_DISABLE, $urandom, 1'($urandom_range(1))));
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_in != n_out) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_settings(input mcs_cfg_t s);
    logic [31:0] vals [8];
    logic [31:0] junk;
    int          i;
    junk    = $urandom;
    // unused upper data bits carry junk
    vals[0] = {junk[31:TICK_W], s.enter_delay};
    vals[1] = {junk[31:TICK_W], s.feedback_hold};
    vals[2] = {junk[31:TICK_W], s.motion_hold};
    vals[3] = {junk[31:POS_W], s.move_pos};
    vals[4] = {junk[31:POS_W], s.home_pos};
    vals[5] = {junk[31:CODE12_W], s.motion_kp};
    vals[6] = {junk[31:CODE12_W], s.motion_kd};
    vals[7] = s.unlock_key;
    for (i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    cur = s;
  endtask

  task automatic run_sequence();
    logic [2:0] code;
    int         span;
    int         k;
    if ($urandom_range(9) < 2) begin
      repeat ($urandom_range(1, 6)) push_item(rand_item());
    end else begin
      case ($urandom_range(2))
        0:       code = RQ_HANDSHAKE;
        1:       code = RQ_MOVE_PLUS;
        default: code = RQ_MOVE_HOME;
      endcase
      if (code != RQ_HANDSHAKE)
        push_item(mk(REQ_UNLOCK, 3'($urandom_range(7)),
                     ($urandom_range(9) == 0) ? $urandom : cur.unlock_key,
                     1'($urandom_range(1))));
      push_item(mk(REQ_USER, code, $urandom, ($urandom_range(19) != 0)));
      span = cur.enter_delay + 3 +
             ((code == RQ_HANDSHAKE) ? cur.feedback_hold : cur.motion_hold);
      if (span > SPAN_CAP) span = SPAN_CAP;
      if ($urandom_range(4) == 0) span = $urandom_range(span);
      for (k = 0; k < span; k++) begin
        // occasional request or key write in the middle of a run
        if ($urandom_range(29) == 0)
          push_item(mk(2'($urandom_range(1, 2)), 3'($urandom_range(1, 7)), $urandom,
                       1'($urandom_range(1))));
        push_item(mk(REQ_TICK, 3'($urandom_range(7)), $urandom,
                     ($urandom_range(39) != 0)));
      end
      if ($urandom_range(3) == 0)
        push_item(mk(REQ_USER, RQ_DISABLE, $urandom, 1'($urandom_range(1))));
    end
  endtask

  task automatic random_phase(input int target);
    int seqs;
    seqs       = 0;
    stim_count = 0;
    while (stim_count < target || seqs < 2) begin
      run_sequence();
      seqs++;
    end
  endtask

  task automatic directed_items();
    push_item(mk(REQ_TICK, RQ_NONE, 32'h0, 1'b0));          // tick while idle
    push_item(mk(REQ_USER, RQ_NONE, 32'hFFFF_FFFF, 1'b1));  // no request
    push_item(mk(REQ_USER, 3'd5, 32'h0, 1'b1));             // invalid codes
    push_item(mk(REQ_USER, 3'd7, 32'h0, 1'b0));
    push_item(mk(REQ_USER, RQ_MOVE_PLUS, 32'h0, 1'b1));     // no key yet
    push_item(mk(REQ_UNLOCK, RQ_NONE, ~RST_UNLOCK_KEY, 1'b1));
    push_item(mk(REQ_USER, RQ_MOVE_HOME, 32'h0, 1'b1));     // wrong key
    push_item(mk(2'd3, 3'd7, 32'hFFFF_FFFF, 1'b1));         // ignored type
    push_item(mk(REQ_UNLOCK, 3'd7, RST_UNLOCK_KEY, 1'b0));
    push_item(mk(REQ_USER, RQ_MOVE_PLUS, 32'h0, 1'b0));     // enter refused
    push_item(mk(REQ_USER, RQ_DISABLE, 32'h0, 1'b0));       // exit refused
    push_item(mk(REQ_USER, RQ_DISABLE, 32'h0, 1'b1));
    push_item(mk(REQ_UNLOCK, RQ_NONE, RST_UNLOCK_KEY, 1'b1));
    push_item(mk(REQ_USER, RQ_MOVE_HOME, 32'h0, 1'b1));
    push_item(mk(REQ_USER, RQ_HANDSHAKE, 32'h0, 1'b1));     // busy
    push_item(mk(REQ_USER, 3'd6, 32'h0, 1'b1));             // busy, not bad
    push_item(mk(REQ_UNLOCK, RQ_NONE, 32'h0, 1'b1));
    push_item(mk(REQ_TICK, RQ_NONE, 32'h0, 1'b1));
    push_item(mk(REQ_USER, RQ_DISABLE, 32'h0, 1'b1));
    push_item(mk(REQ_USER, RQ_HANDSHAKE, 32'h0, 1'b1));
    push_item(mk(REQ_USER, RQ_MOVE_PLUS, 32'h0, 1'b1));     // busy
    push_item(mk(REQ_TICK, RQ_NONE, 32'h0, 1'b0));          // tick, still counting
    push_item(mk(REQ_USER, RQ_DISABLE, 32'h0, 1'b0));
    push_item(mk(REQ_UNLOCK, RQ_NONE, 32'hFFFF_FFFF, 1'b1));
    push_item(mk(REQ_USER, RQ_HANDSHAKE, 32'h0, 1'b0));     // enter refused
  endtask

  initial begin : stimulus
    mcs_cfg_t s;
    int       p;
    rst          <= 1'b1;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_ENTER_DELAY;
    cfg_data     <= '0;
    hold_req_cnt <= 0;
    send_idle  = 0;
    recv_stall = 0;
    stim_count = 0;
    cur = '{enter_delay: RST_ENTER_DELAY, feedback_hold: RST_FEEDBACK_HOLD,
            motion_hold: RST_MOTION_HOLD, move_pos: RST_MOVE_POS,
            home_pos: RST_HOME_POS, motion_kp: RST_MOTION_KP,
            motion_kd: RST_MOTION_KD, unlock_key: RST_UNLOCK_KEY};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    directed_items();

    for (p = 0; p < 5; p++) begin
      drain();
      s = '{enter_delay: TICK_W'($urandom_range(6)),
            feedback_hold: TICK_W'($urandom_range(6)),
            motion_hold: TICK_W'($urandom_range(6)), move_pos: POS_W'($urandom),
            home_pos: POS_W'($urandom), motion_kp: CODE12_W'($urandom_range(4095)),
            motion_kd: CODE12_W'($urandom_range(4095)), unlock_key: $urandom};
      case (p)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
        end
        1: begin
          // all-zero registers: a zero key opens moves without a key write
          send_idle  = 59;
          recv_stall = 0;
          s = '0;
        end
        2: begin
          send_idle  = 0;
          recv_stall = 59;
        end
        3: begin
          send_idle  = 35;
          recv_stall = 35;
          s = '1;
        end
        default: begin
          send_idle  = 0;
          recv_stall = 0;
          s = '{enter_delay: RST_ENTER_DELAY, feedback_hold: RST_FEEDBACK_HOLD,
                motion_hold: RST_MOTION_HOLD, move_pos: RST_MOVE_POS,
                home_pos: RST_HOME_POS, motion_kp: RST_MOTION_KP,
                motion_kd: RST_MOTION_KD, unlock_key: RST_UNLOCK_KEY};
        end
      endcase
      apply_settings(s);
      // fill the block against a stopped receiver
      if (p == 0) hold_req_cnt <= hold_req_cnt + 1;
      random_phase((p == 4) ? 40 : 100);
    end

    drain();
    repeat (3) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
